FILE: rtl/mhpq_pkg.sv
// Shared constants, codes and types of the max-heap priority queue.
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 11;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STEP_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_SELECT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_cmd_t;

endpackage

FILE: rtl/mhpq_cell.sv
// One cell of the sorted key chain: holds one key, shifts or inserts with its neighbours.
module mhpq_cell (
  input  logic                            clk,
  input  mhpq_pkg::cell_cmd_t             cmd,
  input  logic                            used,
  input  logic signed [mhpq_pkg::KEY_W-1:0] prev_key,
  input  logic                            prev_ge,
  input  logic signed [mhpq_pkg::KEY_W-1:0] next_key,
  output logic signed [mhpq_pkg::KEY_W-1:0] key,
  output logic                            ge
);

  // new key belongs at or before this place
  assign ge = !used || (cmd.key > key);

  always_ff @(posedge clk) begin
    case (cmd.op)
      mhpq_pkg::CELL_INSERT: begin
        if (ge) begin
          key <= prev_ge ? prev_key : cmd.key;
        end
      end
      mhpq_pkg::CELL_LEFT:  key <= next_key;
      mhpq_pkg::CELL_RIGHT: key <= prev_key;
      default: ;
    endcase
  end

endmodule

FILE: rtl/max_heap_priority_queue_top.sv
// Top level of the max-priority queue: chain of sorted key cells and its sequencer.
//
//  channel  dir  fields (low bit up)                      transfer when
//  s_*      in   tdata: key_in[31:0] rank[42:32]          s_tvalid & s_tready
//                tuser: func[1:0]
//  m_*      out  tdata: key_out[31:0] count_out[42:32]    m_tvalid & m_tready
//                tuser: status[1:0]
//
// Keys sit in descending order, one per cell.
// Select of rank k rotates the ring left k-1 times, reads cell 0 and rotates back;
// the ring shifts one place per cycle.
// rst clears the count and the sequencer; no clearing pass is needed.
// A new transfer is taken when idle and the output register is free or draining.
module max_heap_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // key_in[31:0], rank[42:32], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // key_out[31:0], count_out[42:32], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);

  typedef enum logic [1:0] {
    IDLE,
    ROT_L,
    ROT_R
  } state_t;

  state_t                                   state;
  logic [mhpq_pkg::CNT_W-1:0]               count;
  logic [mhpq_pkg::STEP_W-1:0]              step;
  logic [mhpq_pkg::STEP_W-1:0]              steps;
  logic signed [mhpq_pkg::KEY_W-1:0]        key_r;
  logic [1:0]                               status_r;
  logic [mhpq_pkg::CNT_W-1:0]               count_r;

  logic                                     acc;
  logic                                     post;
  logic [1:0]                               func;
  logic signed [mhpq_pkg::KEY_W-1:0]        key_in;
  logic [mhpq_pkg::RANK_W-1:0]              rank;
  logic [mhpq_pkg::RANK_W-1:0]              rank_m1;
  logic                                     full;
  logic                                     empty;
  logic                                     rank_ok;
  mhpq_pkg::cell_cmd_t                      cmd;

  logic signed [mhpq_pkg::KEY_W-1:0]        cell_key [mhpq_pkg::CAPACITY];
  logic                                     cell_ge  [mhpq_pkg::CAPACITY];

  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;
  assign func     = s_tuser;
  assign key_in   = $signed(s_tdata[31:0]);
  assign rank     = s_tdata[42:32];
  assign rank_m1  = rank - mhpq_pkg::RANK_W'(1);
  assign full     = (count == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign rank_ok  = (rank != '0) && (rank <= count);

  // a result is loaded into the output register this cycle
  assign post = ((state == IDLE) && acc && !((func == mhpq_pkg::FN_SELECT) && rank_ok)) ||
                ((state == ROT_L) && (step == '0));

  assign m_tdata  = {5'b0, count_r, key_r};
  assign m_tuser  = status_r;

  always_comb begin
    cmd.op  = mhpq_pkg::CELL_HOLD;
    cmd.key = key_in;
    case (state)
      IDLE: begin
        if (acc && func == mhpq_pkg::FN_INSERT && !full) begin
          cmd.op = mhpq_pkg::CELL_INSERT;
        end else if (acc && func == mhpq_pkg::FN_DELETE && !empty) begin
          cmd.op = mhpq_pkg::CELL_LEFT;
        end
      end
      ROT_L: if (step != '0) cmd.op = mhpq_pkg::CELL_LEFT;
      ROT_R: if (step != '0) cmd.op = mhpq_pkg::CELL_RIGHT;
      default: ;
    endcase
  end

  for (genvar i = 0; i < mhpq_pkg::CAPACITY; i++) begin : g_cell
    localparam int PREV = (i == 0) ? mhpq_pkg::CAPACITY - 1 : i - 1;
    localparam int NEXT = (i == mhpq_pkg::CAPACITY - 1) ? 0 : i + 1;
    logic used;
    logic prev_ge;

    assign used    = (mhpq_pkg::CNT_W'(i) < count);
    assign prev_ge = (i == 0) ? 1'b0 : cell_ge[PREV];

    mhpq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .used     (used),
      .prev_key (cell_key[PREV]),
      .prev_ge  (prev_ge),
      .next_key (cell_key[NEXT]),
      .key      (cell_key[i]),
      .ge       (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !post) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (acc) begin
            key_r <= (func == mhpq_pkg::FN_DELETE && !empty) ? cell_key[0] : '0;
            case (func)
              mhpq_pkg::FN_INSERT: begin
                m_tvalid <= 1'b1;
                if (full) begin
                  status_r <= mhpq_pkg::ST_FULL;
                  count_r  <= count;
                end else begin
                  status_r <= mhpq_pkg::ST_OK;
                  count_r  <= count + 1'b1;
                  count    <= count + 1'b1;
                end
              end
              mhpq_pkg::FN_DELETE: begin
                m_tvalid <= 1'b1;
                if (empty) begin
                  status_r <= mhpq_pkg::ST_EMPTY;
                  count_r  <= count;
                end else begin
                  status_r <= mhpq_pkg::ST_OK;
                  count_r  <= count - 1'b1;
                  count    <= count - 1'b1;
                end
              end
              mhpq_pkg::FN_SELECT: begin
                if (rank_ok) begin
                  state <= ROT_L;
                  step  <= rank_m1[mhpq_pkg::STEP_W-1:0];
                  steps <= rank_m1[mhpq_pkg::STEP_W-1:0];
                end else begin
                  m_tvalid <= 1'b1;
                  status_r <= mhpq_pkg::ST_RANGE;
                  count_r  <= count;
                end
              end
              default: begin
                m_tvalid <= 1'b1;
                status_r <= mhpq_pkg::ST_RANGE;
                count_r  <= count;
              end
            endcase
          end
        end
        ROT_L: begin
          if (step == '0) begin
            m_tvalid <= 1'b1;
            key_r    <= cell_key[0];
            status_r <= mhpq_pkg::ST_OK;
            count_r  <= count;
            if (steps == '0) begin
              state <= IDLE;
            end else begin
              state <= ROT_R;
              step  <= steps;
            end
          end else begin
            step <= step - 1'b1;
          end
        end
        ROT_R: begin
          if (step == '0) begin
            state <= IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
    else $error("key count above capacity");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |=> $stable(count))
    else $error("count changed during select rotation");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (m_tvalid || state == ROT_L))
    else $error("accepted transfer produced neither result nor rotation");

  a_rot_r_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == ROT_L && step == '0) |=> m_tvalid)
    else $error("select capture did not post a result");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the max-heap priority queue top level.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [mhpq_pkg::KEY_W-1:0] key;
    logic [1:0]                        status;
    logic [mhpq_pkg::CNT_W-1:0]        count;
  } heap_reply_t;

  class heap_mirror_t;
    logic signed [mhpq_pkg::KEY_W-1:0] bank [2][mhpq_pkg::CAPACITY];
    int unsigned held;
    int unsigned peak;
    heap_reply_t awaited[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned replies;
    int unsigned status_seen [4];

    function new();
      held = 0;
      peak = 0;
      errors = 0;
      requests = 0;
      replies = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void sift_up(int unsigned pos);
      int unsigned parent;
      logic signed [mhpq_pkg::KEY_W-1:0] t;
      while (pos != 0) begin
        parent = (pos - 1) / 2;
        if (bank[0][pos] > bank[0][parent]) begin
          t = bank[0][pos];
          bank[0][pos] = bank[0][parent];
          bank[0][parent] = t;
          pos = parent;
        end else begin
          break;
        end
      end
    endfunction

    // bank 0 holds the heap, bank 1 is the working copy for select
    function void sift_down(int b, int unsigned n);
      int unsigned pos, lc, rc, big;
      logic signed [mhpq_pkg::KEY_W-1:0] t;
      pos = 0;
      forever begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= n) break;
        big = lc;
        if (rc < n && !(bank[b][lc] > bank[b][rc])) big = rc;
        if (bank[b][pos] < bank[b][big]) begin
          t = bank[b][pos];
          bank[b][pos] = bank[b][big];
          bank[b][big] = t;
          pos = big;
        end else begin
          break;
        end
      end
    endfunction

    function void take_request(logic [1:0] fn, logic signed [mhpq_pkg::KEY_W-1:0] key,
                               logic [mhpq_pkg::RANK_W-1:0] rank);
      heap_reply_t exp;
      int unsigned n;
      int unsigned i;
      exp.key = '0;
      exp.status = mhpq_pkg::ST_OK;
      requests++;
      case (fn)
        mhpq_pkg::FN_INSERT: begin
          if (held >= mhpq_pkg::CAPACITY) begin
            exp.status = mhpq_pkg::ST_FULL;
          end else begin
            bank[0][held] = key;
            sift_up(held);
            held++;
          end
        end
        mhpq_pkg::FN_DELETE: begin
          if (held == 0) begin
            exp.status = mhpq_pkg::ST_EMPTY;
          end else begin
            exp.key = bank[0][0];
            held--;
            bank[0][0] = bank[0][held];
            sift_down(0, held);
          end
        end
        mhpq_pkg::FN_SELECT: begin
          if (rank == 0 || rank > held) begin
            exp.status = mhpq_pkg::ST_RANGE;
          end else begin
            n = held;
            for (i = 0; i < held; i++) bank[1][i] = bank[0][i];
            for (i = 1; i < rank; i++) begin
              n--;
              bank[1][0] = bank[1][n];
              sift_down(1, n);
            end
            exp.key = bank[1][0];
          end
        end
        default: exp.status = mhpq_pkg::ST_RANGE;
      endcase
      if (held > peak) peak = held;
      exp.count = held[mhpq_pkg::CNT_W-1:0];
      status_seen[exp.status]++;
      awaited.push_back(exp);
    endfunction

    function void match_reply(logic signed [mhpq_pkg::KEY_W-1:0] key, logic [1:0] status,
                              logic [mhpq_pkg::CNT_W-1:0] count);
      heap_reply_t exp;
      if (awaited.size() == 0) begin
        $error("reply with no request outstanding: key_out %0d status %0d count_out %0d",
               key, status, count);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      replies++;
      if (key !== exp.key) begin
        $error("key_out: expected %0d, got %0d", exp.key, key);
        errors++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        errors++;
      end
      if (count !== exp.count) begin
        $error("count_out: expected %0d, got %0d", exp.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  heap_mirror_t mirror = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_ticket = 0;
  int unsigned items_offered = 0;
  int unsigned quiet = 0;

  max_heap_priority_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      mirror.match_reply(m_tdata[31:0], m_tuser, m_tdata[42:32]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : receiver
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic offer(input logic [1:0] fn, input logic signed [mhpq_pkg::KEY_W-1:0] key,
                       input logic [mhpq_pkg::RANK_W-1:0] rank);
    case ((items_offered / 100) % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 19; stall_pct = 19; end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, rank, key};
    s_tuser  <= fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.take_request(fn, key, rank);
    items_offered++;
  endtask

  // weights in percent; the remainder goes to the spare selector
  task automatic random_request(input int ins_w, input int del_w, input int sel_w);
    int unsigned roll;
    logic [1:0] fn;
    logic signed [mhpq_pkg::KEY_W-1:0] key;
    logic [mhpq_pkg::RANK_W-1:0] rank;
    roll = $urandom_range(99);
    if (roll < ins_w) fn = mhpq_pkg::FN_INSERT;
    else if (roll < ins_w + del_w) fn = mhpq_pkg::FN_DELETE;
    else if (roll < ins_w + del_w + sel_w) fn = mhpq_pkg::FN_SELECT;
    else fn = FN_SPARE;
    case ($urandom_range(9))
      0, 1: key = $urandom_range(4) - 2;
      2: key = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: key = $urandom();
    endcase
    roll = $urandom_range(9);
    if (mirror.held > 0 && roll < 4)
      rank = mhpq_pkg::RANK_W'($urandom_range((mirror.held < 8) ? mirror.held : 8, 1));
    else if (mirror.held > 0 && roll < 7)
      rank = mhpq_pkg::RANK_W'($urandom_range(mirror.held, 1));
    else if (roll == 7)
      rank = '0;
    else
      rank = mhpq_pkg::RANK_W'($urandom_range(2047));
    offer(fn, key, rank);
  endtask

  initial begin : stimulus
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, spare selector, extreme keys, duplicates, rank edges
    offer(mhpq_pkg::FN_DELETE, 32'hFFFF_FFFF, 11'h7FF);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd1);
    offer(FN_SPARE,            32'h7FFF_FFFF, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'h7FFF_FFFF, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'h8000_0000, 11'h7FF);
    offer(mhpq_pkg::FN_INSERT, 32'h0, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'hFFFF_FFFF, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'h1, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'h7FFF_FFFF, 11'd0);
    offer(mhpq_pkg::FN_INSERT, 32'h0, 11'd0);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd0);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd1);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd7);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd8);
    offer(mhpq_pkg::FN_SELECT, 32'hFFFF_FFFF, 11'h7FF);
    offer(FN_SPARE,            32'hFFFF_FFFF, 11'h7FF);
    for (i = 0; i < 8; i++) offer(mhpq_pkg::FN_DELETE, 32'h0, 11'd0);
    offer(mhpq_pkg::FN_SELECT, 32'h0, 11'd1024);

    // output held off while the sender keeps offering
    hold_ticket++;
    for (i = 0; i < 150; i++) random_request(45, 30, 20);

    // fill to capacity, then push against the full queue
    while (mirror.held < mhpq_pkg::CAPACITY) random_request(94, 2, 3);
    for (i = 0; i < 20; i++) random_request(90, 4, 5);

    hold_ticket++;
    for (i = 0; i < 100; i++) random_request(25, 55, 15);
    for (i = 0; i < 60; i++) random_request(40, 40, 15);

    s_tvalid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d requests, %0d replies checked; peak occupancy %0d of %0d",
             mirror.requests, mirror.replies, mirror.peak, mhpq_pkg::CAPACITY);
    $display("status ok %0d, full %0d, empty %0d, out of range %0d",
             mirror.status_seen[mhpq_pkg::ST_OK], mirror.status_seen[mhpq_pkg::ST_FULL],
             mirror.status_seen[mhpq_pkg::ST_EMPTY], mirror.status_seen[mhpq_pkg::ST_RANGE]);
    if (mirror.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
